### rtl/sfac_pkg.sv
package sfac_pkg;

   // Count width inside the block and width of each reported count
   localparam int CountBits = 8;
   localparam int OutBits   = 8;
   localparam int NumElems  = 8;

   // Element slots, in result order
   localparam logic [2:0] ElemC  = 3'd0;
   localparam logic [2:0] ElemH  = 3'd1;
   localparam logic [2:0] ElemN  = 3'd2;
   localparam logic [2:0] ElemO  = 3'd3;
   localparam logic [2:0] ElemF  = 3'd4;
   localparam logic [2:0] ElemBr = 3'd5;
   localparam logic [2:0] ElemAr = 3'd6;
   localparam logic [2:0] ElemHe = 3'd7;

   // Pending symbol codes: 1..8 are element slot + 1
   localparam logic [3:0] PendNone   = 4'd0;
   localparam logic [3:0] PendFirst  = 4'd1;
   localparam logic [3:0] PendLast   = 4'd8;
   localparam logic [3:0] PendWaitAr = 4'd9;
   localparam logic [3:0] PendWaitBr = 4'd10;
   localparam logic [3:0] PendWaitH  = 4'd11;

   // ASCII codes
   localparam logic [7:0] ChHyphen = 8'h2D;
   localparam logic [7:0] ChZero   = 8'h30;
   localparam logic [7:0] ChNine   = 8'h39;
   localparam logic [7:0] ChA      = 8'h41;
   localparam logic [7:0] ChB      = 8'h42;
   localparam logic [7:0] ChC      = 8'h43;
   localparam logic [7:0] ChE      = 8'h45;
   localparam logic [7:0] ChF      = 8'h46;
   localparam logic [7:0] ChH      = 8'h48;
   localparam logic [7:0] ChN      = 8'h4E;
   localparam logic [7:0] ChO      = 8'h4F;
   localparam logic [7:0] ChR      = 8'h52;
   localparam logic [7:0] ChLowA   = 8'h61;
   localparam logic [7:0] ChLowZ   = 8'h7A;
   localparam logic [7:0] CaseGap  = 8'h20;

   typedef logic [CountBits-1:0] count_type;

   typedef struct packed {
      logic [NumElems-1:0][CountBits-1:0] totals;
      logic [3:0]                         pend;
      count_type                          dval;
      logic                               dnz;
      logic                               err;
   } parse_state_type;

   typedef struct packed {
      logic [NumElems-1:0][OutBits-1:0] counts;
      logic                             error;
   } result_type;

   // Decode the first character of a symbol: {error, pending code}
   function automatic logic [4:0] start_code(input logic [7:0] c);
      logic [7:0] u;
      logic [4:0] r;
      u = (c >= ChLowA && c <= ChLowZ) ? 8'(c - CaseGap) : c;
      priority if (c == ChA) begin
         r = {1'b0, PendWaitAr};
      end else if (c == ChB) begin
         r = {1'b0, PendWaitBr};
      end else if (c == ChH) begin
         r = {1'b0, PendWaitH};
      end else begin
         unique case (u)
            ChC:     r = {1'b0, 4'({1'b0, ElemC}) + PendFirst};
            ChH:     r = {1'b0, 4'({1'b0, ElemH}) + PendFirst};
            ChN:     r = {1'b0, 4'({1'b0, ElemN}) + PendFirst};
            ChO:     r = {1'b0, 4'({1'b0, ElemO}) + PendFirst};
            ChF:     r = {1'b0, 4'({1'b0, ElemF}) + PendFirst};
            ChB:     r = {1'b0, 4'({1'b0, ElemBr}) + PendFirst};
            ChA:     r = {1'b0, 4'({1'b0, ElemAr}) + PendFirst};
            ChE:     r = {1'b0, 4'({1'b0, ElemHe}) + PendFirst};
            default: r = {1'b1, PendNone};
         endcase
      end
      return r;
   endfunction

endpackage

### rtl/species_formula_atom_counter.sv
// Species formula atom counter.
// The req channel carries one character of a species name per beat
// (tdata = name_char, tlast marks the final character). After the final
// beat the rsp channel presents one beat: tdata holds eight 8-bit atom
// counts, carbon lowest, then H, N, O, F, Br, Ar, He; tuser flags an
// unknown symbol, in which case all counts are zero.
// The result is registered and is valid in the cycle after the last
// character is accepted. Throughput: one character per clock while no
// result waits to be taken; the parser state is updated by a single
// combinational step between its state register and the result register.
// A hyphen restarts the count; after a last beat the parser returns to
// its reset state, so names may follow back to back.
// Reset (synchronous, active high) clears the parser and drops rsp_tvalid.
// When the receiver stalls, the result register holds its beat and
// req_tready falls until the result is taken; characters already inside
// are never lost.
module species_formula_atom_counter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] name_char
   input  logic        req_tlast,   // last_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // carbon, hydrogen, nitrogen, oxygen, fluorine,
                                    // bromine, argon, helium atoms (8 bits each)
   output logic [0:0]  rsp_tuser    // [0] name_error
);
   import sfac_pkg::*;

   parse_state_type state_ff;
   parse_state_type state_in;
   result_type      result_in;
   result_type      rsp_data_ff;
   logic            rsp_valid_ff;
   logic            req_beat;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_beat   = req_tvalid && req_tready;

   sfac_step u_step (
      .state_cur (state_ff),
      .name_char (req_tdata),
      .last_char (req_tlast),
      .state_nxt (state_in),
      .result    (result_in)
   );

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_beat) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_beat && req_tlast) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat && req_tlast) begin
         rsp_data_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff.counts;
   assign rsp_tuser  = rsp_data_ff.error;

endmodule

### rtl/sfac_step.sv
module sfac_step (
   input  sfac_pkg::parse_state_type state_cur,
   input  logic [7:0]                name_char,
   input  logic                      last_char,
   output sfac_pkg::parse_state_type state_nxt,
   output sfac_pkg::result_type      result
);
   import sfac_pkg::*;

   logic            is_digit;
   logic [3:0]      dig;
   logic [4:0]      sc;
   logic            h_follow;
   parse_state_type s;
   count_type       n;
   count_type       dval_x10;

   assign is_digit = (name_char >= ChZero) && (name_char <= ChNine);
   assign dig      = 4'(name_char - ChZero);
   assign sc       = start_code(name_char);
   assign h_follow = (name_char == ChC) || (name_char == ChN) || (name_char == ChF) ||
                     (name_char == ChA) || (name_char == ChH) || (name_char == ChO) ||
                     (name_char == ChB);
   assign dval_x10 = (state_cur.dval << 3) + (state_cur.dval << 1)
                     + {{(CountBits-4){1'b0}}, dig};

   // One character step, then the end-of-name flush
   always_comb begin
      s = state_cur;
      n = '0;
      if (name_char == ChHyphen) begin
         s = '0;
      end else if (!s.err) begin
         priority if (s.pend == PendNone) begin
            s.pend = sc[3:0];
            s.dval = '0;
            s.dnz  = 1'b0;
            if (sc[4]) begin
               s     = '0;
               s.err = 1'b1;
            end
         end else if (s.pend == PendWaitAr || s.pend == PendWaitBr) begin
            if (name_char == ChR) begin
               s.pend = (s.pend == PendWaitAr) ? 4'({1'b0, ElemAr}) + PendFirst
                                               : 4'({1'b0, ElemBr}) + PendFirst;
               s.dval = '0;
               s.dnz  = 1'b0;
            end else begin
               s     = '0;
               s.err = 1'b1;
            end
         end else if (s.pend == PendWaitH) begin
            if (name_char == ChE) begin
               s.pend = 4'({1'b0, ElemHe}) + PendFirst;
               s.dval = '0;
               s.dnz  = 1'b0;
            end else if (is_digit) begin
               s.pend = 4'({1'b0, ElemH}) + PendFirst;
               s.dval = {{(CountBits-4){1'b0}}, dig};
               s.dnz  = (dig != 4'd0);
            end else if (h_follow) begin
               // hydrogen with a count of one, then the new symbol
               s.totals[ElemH] = s.totals[ElemH] + count_type'(1);
               s.pend          = sc[3:0];
               s.dval          = '0;
               s.dnz           = 1'b0;
            end else begin
               s     = '0;
               s.err = 1'b1;
            end
         end else if (s.pend >= PendFirst && s.pend <= PendLast) begin
            if (is_digit) begin
               s.dval = dval_x10;
               s.dnz  = s.dnz | (dig != 4'd0);
            end else begin
               // close the pending element, then decode the new symbol
               n = s.dnz ? s.dval : count_type'(1);
               for (int i = 0; i < NumElems; i++) begin
                  if (4'(i) + PendFirst == s.pend) begin
                     s.totals[i] = s.totals[i] + n;
                  end
               end
               s.pend = sc[3:0];
               s.dval = '0;
               s.dnz  = 1'b0;
               if (sc[4]) begin
                  s     = '0;
                  s.err = 1'b1;
               end
            end
         end else begin
            s     = '0;
            s.err = 1'b1;
         end
      end

      // End of name: flush the pending element; an unfinished Ar or Br is an error
      if (last_char && !s.err) begin
         priority if (s.pend == PendWaitAr || s.pend == PendWaitBr) begin
            s     = '0;
            s.err = 1'b1;
         end else if (s.pend == PendWaitH) begin
            s.totals[ElemH] = s.totals[ElemH] + count_type'(1);
         end else begin
            n = s.dnz ? s.dval : count_type'(1);
            for (int i = 0; i < NumElems; i++) begin
               if (4'(i) + PendFirst == s.pend) begin
                  s.totals[i] = s.totals[i] + n;
               end
            end
         end
      end

      for (int i = 0; i < NumElems; i++) begin
         result.counts[i] = s.totals[i][OutBits-1:0];
      end
      result.error = s.err;

      // a finished name leaves the parser in its reset state
      state_nxt = last_char ? parse_state_type'('0) : s;
   end

endmodule
